// File: hw/rtl/deadline_event_queue_dispatcher_top_assert.svh
// ----------------------------------------------------------------------------
// Dispatcher assertion macros
// Implication and next-cycle checks, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_EVENT_QUEUE_DISPATCHER_TOP_ASSERT_SVH
`define DEADLINE_EVENT_QUEUE_DISPATCHER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DEDQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dispatcher check failed");
`define DEDQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dispatcher check failed");
`else
`define DEDQ_ASSERT_IMP(lbl, ante, cons)
`define DEDQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/dedq_pkg.sv
// ----------------------------------------------------------------------------
// dedq_pkg
// Types and codes of the deadline event queue dispatcher.
// ----------------------------------------------------------------------------
package dedq_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EV, S_PICK, S_SERVE, S_ADD, S_FLIP, S_POST, S_CRD, S_CEV, S_FIN
  } state_t;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DISP  = 2'd1;
  localparam logic [1:0] OP_COMP  = 2'd2;
  localparam logic [1:0] OP_START = 2'd3;

  localparam logic [3:0] K_PUSHA    = 4'd0;
  localparam logic [3:0] K_PUSHB    = 4'd1;
  localparam logic [3:0] K_LEDON_LO = 4'd2;
  localparam logic [3:0] K_LEDON_HI = 4'd5;
  localparam logic [3:0] K_LEDOFF_LO = 4'd6;
  localparam logic [3:0] K_LEDOFF_HI = 4'd9;
  localparam logic [3:0] K_PES_ON   = 4'd10;
  localparam logic [3:0] K_PES_OFF  = 4'd11;
  localparam logic [3:0] K_PRINT    = 4'd12;
  localparam logic [3:0] K_ERROR    = 4'd13;

  localparam logic [2:0] A_NONE  = 3'd0;
  localparam logic [2:0] A_PULSA = 3'd1;
  localparam logic [2:0] A_PULSB = 3'd2;
  localparam logic [2:0] A_LED   = 3'd3;
  localparam logic [2:0] A_PES   = 3'd4;
  localparam logic [2:0] A_PRINT = 3'd5;
  localparam logic [2:0] A_ERROR = 3'd6;

  localparam logic [7:0] ERR_FULL    = 8'd0;
  localparam logic [7:0] ERR_UNKNOWN = 8'd1;

  localparam logic CFG_CLEAN  = 1'b0;
  localparam logic CFG_REMOVE = 1'b1;

  localparam logic [4:0] CLEAN_RST  = 5'd8;
  localparam logic [4:0] REMOVE_RST = 5'd12;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] led;
    logic       level;
    logic [7:0] pkg;
    logic [7:0] weight;
    logic [7:0] err;
  } res_t;

endpackage

// File: hw/rtl/deadline_event_queue_dispatcher_top.sv
// ----------------------------------------------------------------------------
// deadline_event_queue_dispatcher_top
// Timed event table with add, dispatch burst, compact and start operations.
// A dispatch serves up to BURST_LIMIT events, each found by a scan of the
// table that an error entry ends at once, then compacts the table when the
// count is above the clean threshold and not above the remove threshold.
// One word in work at a time; in_ready returns in the same cycle that the
// last result word is presented.
// Synchronous reset clears count and error mode, sets the scale state idle
// and loads the reset thresholds; the entry tables are not cleared.
// ----------------------------------------------------------------------------
module deadline_event_queue_dispatcher_top
  import dedq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int BURST_LIMIT = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_event_kind,
  input  logic [15:0] in_due_time,
  input  logic [7:0]  in_payload,
  input  logic [15:0] in_now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [1:0]  out_led_index,
  output logic        out_line_level,
  output logic [7:0]  out_package_kind,
  output logic [7:0]  out_weight,
  output logic [7:0]  out_error_code,
  output logic [4:0]  out_queue_count,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(BURST_LIMIT + 1);
  localparam int TW = (AW > 5) ? AW : 5;

  logic [3:0]  kind_mem [QUEUE_DEPTH];
  logic [15:0] due_mem  [QUEUE_DEPTH];
  logic [7:0]  pay_mem  [QUEUE_DEPTH];
  logic        dead_mem [QUEUE_DEPTH];

  state_t state_r, state_nxt;

  logic [AW-1:0] cnt_r, cnt_nxt, ptr_r, ptr_nxt, wr_r, wr_nxt;
  logic          err_r, err_nxt, scale_r, scale_nxt;
  logic [4:0]    clean_thr_r, remove_thr_r;
  logic [NW-1:0] n_r, n_nxt;
  logic [7:0]    pkg_r, pkg_nxt;
  logic [15:0]   now_r, now_nxt;
  logic          disp_r, disp_nxt;

  logic [3:0]  a_kind_r, a_kind_nxt;
  logic [15:0] a_due_r, a_due_nxt;
  logic [7:0]  a_pay_r, a_pay_nxt;
  logic        a_rem_r, a_rem_nxt;

  logic [3:0]  q_kind_r;
  logic [15:0] q_due_r;
  logic [7:0]  q_pay_r;
  logic        q_dead_r;

  logic          cand_v_r, cand_v_nxt, pb_v_r, pb_v_nxt;
  logic [AW-1:0] cand_idx_r, cand_idx_nxt, pb_idx_r, pb_idx_nxt, sel_idx_r, sel_idx_nxt;
  logic [3:0]    cand_kind_r, cand_kind_nxt, sel_kind_r, sel_kind_nxt;
  logic [7:0]    cand_pay_r, cand_pay_nxt, pb_pay_r, pb_pay_nxt, sel_pay_r, sel_pay_nxt;

  res_t hold_r, hold_nxt, out_r, out_nxt, res;
  logic hold_v_r, hold_v_nxt;
  logic ov_r, ov_nxt, olast_r, olast_nxt;
  logic [4:0] ocnt_r, ocnt_nxt;

  logic          we_kp, we_due, we_dead, wdead;
  logic [AW-1:0] wa;
  logic [3:0]    wkind;
  logic [15:0]   wdue;
  logic [7:0]    wpay;

  logic        room_srv, room_fin, q_live, q_err, pick_pb, scan_end, burst_done;
  logic        post_compact, sel_unk, srv_add, due_hit;
  logic [15:0] prev_t;
  logic [TW-1:0] cnt_w;
  logic [3:0]  led_on, led_off;

  assign room_srv   = !hold_v_r || !ov_r || out_ready;
  assign room_fin   = !ov_r || out_ready;
  assign q_live     = !q_dead_r;
  assign q_err      = q_live && (q_kind_r == K_ERROR);
  assign pick_pb    = cand_v_r && (cand_kind_r == K_PUSHA) && pb_v_r;
  assign scan_end   = (ptr_r >= cnt_r);
  assign burst_done = (n_r == NW'(BURST_LIMIT - 1));
  assign cnt_w      = TW'(cnt_r);
  assign post_compact = !(cnt_w > TW'(remove_thr_r)) && (cnt_w > TW'(clean_thr_r));
  assign sel_unk    = (sel_kind_r > K_ERROR);
  assign srv_add    = ((sel_kind_r == K_PUSHA) && scale_r) || sel_unk;
  assign prev_t     = now_r - 16'd1;
  assign due_hit    = (q_due_r == now_r) || (q_due_r == prev_t);
  assign led_on     = sel_kind_r - K_LEDON_LO;
  assign led_off    = sel_kind_r - K_LEDOFF_LO;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = ov_r;
  assign out_action       = out_r.action;
  assign out_led_index    = out_r.led;
  assign out_line_level   = out_r.level;
  assign out_package_kind = out_r.pkg;
  assign out_weight       = out_r.weight;
  assign out_error_code   = out_r.err;
  assign out_queue_count  = ocnt_r;
  assign out_last         = olast_r;

  // result word of the served entry
  always_comb begin
    res = '0;
    case (sel_kind_r) inside
      K_PUSHA: begin
        res.action = scale_r ? A_PULSA : A_NONE;
      end
      K_PUSHB: begin
        res.action = A_PULSB;
      end
      [K_LEDON_LO:K_LEDON_HI]: begin
        res.action = A_LED;
        res.led    = led_on[1:0];
      end
      [K_LEDOFF_LO:K_LEDOFF_HI]: begin
        res.action = A_LED;
        res.led    = led_off[1:0];
        res.level  = 1'b1;
      end
      K_PES_ON: begin
        res.action = A_PES;
        res.level  = 1'b1;
      end
      K_PES_OFF: begin
        res.action = A_PES;
      end
      K_PRINT: begin
        res.action = A_PRINT;
        res.pkg    = pkg_r;
        res.weight = sel_pay_r;
      end
      K_ERROR: begin
        res.action = A_ERROR;
        res.err    = sel_pay_r;
      end
      default: begin
        res.err = ERR_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_ADD:  state_nxt = S_ADD;
            OP_DISP: state_nxt = S_RD;
            OP_COMP: state_nxt = S_CRD;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_RD:    state_nxt = scan_end ? S_PICK : S_EV;
      S_EV:    state_nxt = q_err ? S_SERVE : S_RD;
      S_PICK:  state_nxt = cand_v_r ? S_SERVE : S_POST;
      S_SERVE: if (room_srv) state_nxt = srv_add ? S_ADD : S_FLIP;
      S_ADD:   if (!a_rem_r) state_nxt = disp_r ? S_FLIP : S_FIN;
      S_FLIP:  state_nxt = burst_done ? S_POST : S_RD;
      S_POST:  state_nxt = post_compact ? S_CRD : S_FIN;
      S_CRD:   state_nxt = scan_end ? S_FIN : S_CEV;
      S_CEV:   state_nxt = S_CRD;
      S_FIN:   if (room_fin) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;  ptr_nxt = ptr_r;  wr_nxt = wr_r;
    err_nxt = err_r;  scale_nxt = scale_r;  n_nxt = n_r;
    pkg_nxt = pkg_r;  now_nxt = now_r;  disp_nxt = disp_r;
    a_kind_nxt = a_kind_r;  a_due_nxt = a_due_r;
    a_pay_nxt = a_pay_r;  a_rem_nxt = a_rem_r;
    cand_v_nxt = cand_v_r;  cand_idx_nxt = cand_idx_r;
    cand_kind_nxt = cand_kind_r;  cand_pay_nxt = cand_pay_r;
    pb_v_nxt = pb_v_r;  pb_idx_nxt = pb_idx_r;  pb_pay_nxt = pb_pay_r;
    sel_idx_nxt = sel_idx_r;  sel_kind_nxt = sel_kind_r;  sel_pay_nxt = sel_pay_r;
    hold_nxt = hold_r;  hold_v_nxt = hold_v_r;
    ov_nxt = out_ready ? 1'b0 : ov_r;
    out_nxt = out_r;  olast_nxt = olast_r;  ocnt_nxt = ocnt_r;
    we_kp = 1'b0;  we_due = 1'b0;  we_dead = 1'b0;
    wa = '0;  wkind = '0;  wdue = '0;  wpay = '0;  wdead = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          now_nxt    = in_now_time;
          disp_nxt   = (in_op == OP_DISP);
          a_kind_nxt = in_event_kind;
          a_due_nxt  = in_due_time;
          a_pay_nxt  = in_payload;
          a_rem_nxt  = 1'b0;
          ptr_nxt    = '0;
          wr_nxt     = '0;
          cand_v_nxt = 1'b0;
          pb_v_nxt   = 1'b0;
          n_nxt      = '0;
          pkg_nxt    = '0;
          hold_v_nxt = 1'b0;
          if (in_op == OP_START) begin
            cnt_nxt = '0;
            err_nxt = 1'b0;
          end
        end
      end
      S_EV: begin
        ptr_nxt = ptr_r + 1'b1;
        if (q_err) begin
          sel_idx_nxt  = ptr_r;
          sel_kind_nxt = q_kind_r;
          sel_pay_nxt  = q_pay_r;
        end else if (q_live) begin
          if (due_hit) begin
            cand_v_nxt    = 1'b1;
            cand_idx_nxt  = ptr_r;
            cand_kind_nxt = q_kind_r;
            cand_pay_nxt  = q_pay_r;
          end
          if (q_kind_r == K_PUSHB) begin
            pb_v_nxt   = 1'b1;
            pb_idx_nxt = ptr_r;
            pb_pay_nxt = q_pay_r;
          end
        end
      end
      S_PICK: begin
        if (pick_pb) begin
          sel_idx_nxt  = pb_idx_r;
          sel_kind_nxt = K_PUSHB;
          sel_pay_nxt  = pb_pay_r;
        end else begin
          sel_idx_nxt  = cand_idx_r;
          sel_kind_nxt = cand_kind_r;
          sel_pay_nxt  = cand_pay_r;
        end
      end
      S_SERVE: begin
        if (room_srv) begin
          if (hold_v_r) begin
            ov_nxt    = 1'b1;
            out_nxt   = hold_r;
            ocnt_nxt  = cnt_w[4:0];
            olast_nxt = 1'b0;
          end
          hold_nxt   = res;
          hold_v_nxt = 1'b1;
          if (sel_kind_r == K_PUSHA) begin
            if (scale_r) begin
              scale_nxt  = 1'b0;
              pkg_nxt    = sel_pay_r;
              a_kind_nxt = K_PES_ON;
              a_due_nxt  = now_r;
              a_pay_nxt  = '0;
              a_rem_nxt  = 1'b1;
            end
          end else if (sel_kind_r == K_PUSHB) begin
            scale_nxt = 1'b1;
            pkg_nxt   = '0;
          end else if (sel_kind_r == K_ERROR) begin
            cnt_nxt   = '0;
            err_nxt   = 1'b1;
            scale_nxt = 1'b1;
          end else if (sel_unk) begin
            a_kind_nxt = K_ERROR;
            a_due_nxt  = now_r;
            a_pay_nxt  = ERR_UNKNOWN;
            a_rem_nxt  = 1'b0;
          end
        end
      end
      S_ADD: begin
        if (!err_r) begin
          if (cnt_r == AW'(QUEUE_DEPTH - 1)) begin
            we_kp   = 1'b1;
            wa      = '0;
            wkind   = K_ERROR;
            wpay    = ERR_FULL;
            cnt_nxt = AW'(1);
          end else begin
            we_kp   = 1'b1;
            we_due  = 1'b1;
            we_dead = 1'b1;
            wa      = cnt_r;
            wkind   = a_kind_r;
            wdue    = a_due_r;
            wpay    = a_pay_r;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (a_rem_r) begin
          a_kind_nxt = K_PES_OFF;
          a_due_nxt  = now_r + 16'd1;
          a_pay_nxt  = '0;
          a_rem_nxt  = 1'b0;
        end
      end
      S_FLIP: begin
        we_dead    = 1'b1;
        wa         = sel_idx_r;
        wdead      = 1'b1;
        n_nxt      = n_r + 1'b1;
        ptr_nxt    = '0;
        cand_v_nxt = 1'b0;
        pb_v_nxt   = 1'b0;
      end
      S_POST: begin
        ptr_nxt = '0;
        wr_nxt  = '0;
      end
      S_CRD: begin
        if (scan_end) cnt_nxt = wr_r;
      end
      S_CEV: begin
        ptr_nxt = ptr_r + 1'b1;
        if (q_live) begin
          we_kp   = 1'b1;
          we_due  = 1'b1;
          we_dead = 1'b1;
          wa      = wr_r;
          wkind   = q_kind_r;
          wdue    = q_due_r;
          wpay    = q_pay_r;
          wr_nxt  = wr_r + 1'b1;
        end
      end
      S_FIN: begin
        if (room_fin) begin
          ov_nxt     = 1'b1;
          out_nxt    = hold_v_r ? hold_r : '0;
          ocnt_nxt   = cnt_w[4:0];
          olast_nxt  = 1'b1;
          hold_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_kp) begin
      kind_mem[wa] <= wkind;
      pay_mem[wa]  <= wpay;
    end
    if (we_due) due_mem[wa] <= wdue;
    if (we_dead) dead_mem[wa] <= wdead;
    q_kind_r <= kind_mem[ptr_r];
    q_due_r  <= due_mem[ptr_r];
    q_pay_r  <= pay_mem[ptr_r];
    q_dead_r <= dead_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      err_r        <= 1'b0;
      scale_r      <= 1'b1;
      clean_thr_r  <= CLEAN_RST;
      remove_thr_r <= REMOVE_RST;
      hold_v_r     <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      scale_r  <= scale_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_CLEAN) clean_thr_r <= cfg_wdata;
        else                         remove_thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;  wr_r <= wr_nxt;  n_r <= n_nxt;
    pkg_r <= pkg_nxt;  now_r <= now_nxt;  disp_r <= disp_nxt;
    a_kind_r <= a_kind_nxt;  a_due_r <= a_due_nxt;
    a_pay_r <= a_pay_nxt;  a_rem_r <= a_rem_nxt;
    cand_v_r <= cand_v_nxt;  cand_idx_r <= cand_idx_nxt;
    cand_kind_r <= cand_kind_nxt;  cand_pay_r <= cand_pay_nxt;
    pb_v_r <= pb_v_nxt;  pb_idx_r <= pb_idx_nxt;  pb_pay_r <= pb_pay_nxt;
    sel_idx_r <= sel_idx_nxt;  sel_kind_r <= sel_kind_nxt;  sel_pay_r <= sel_pay_nxt;
    hold_r <= hold_nxt;  out_r <= out_nxt;
    olast_r <= olast_nxt;  ocnt_r <= ocnt_nxt;
  end

`include "deadline_event_queue_dispatcher_top_assert.svh"

  `DEDQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `DEDQ_ASSERT_IMP(a_burst_bound, state_r != S_IDLE, n_r <= NW'(BURST_LIMIT))
  `DEDQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_action, out_queue_count, out_last}))

endmodule

// File: bench/tb_deadline_event_queue_dispatcher_top.sv
// ----------------------------------------------------------------------------
// Deadline event queue dispatcher testbench
// Drives add, dispatch, compact and start words through the valid/ready
// input, predicts every result word from a behavioral copy of the event
// table, and checks each result field by field under random stalls on both
// sides and several threshold settings.
// ----------------------------------------------------------------------------
module tb_deadline_event_queue_dispatcher_top;
  import dedq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int BURST      = 5;
  localparam int STALL_MAX  = 6000;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] led;
    logic       level;
    logic [7:0] pkg;
    logic [7:0] weight;
    logic [7:0] err;
    logic [4:0] count;
    logic       last;
  } word_t;

  class dispatch_scoreboard;
    logic [3:0]  ev_kind [DEPTH];
    logic [15:0] ev_due [DEPTH];
    logic [7:0]  ev_pay [DEPTH];
    bit          ev_dead [DEPTH];
    int          count;
    bit          err_mode;
    bit          scale_idle;
    int          clean_th;
    int          remove_th;
    word_t       pending_words[$];
    int          mismatches;
    int          checked;
    int          served[8];

    function new();
      count = 0;
      err_mode = 0;
      scale_idle = 1;
      clean_th = CLEAN_RST;
      remove_th = REMOVE_RST;
      mismatches = 0;
      checked = 0;
      foreach (ev_dead[i]) ev_dead[i] = 0;
    endfunction

    function void set_thresholds(int clean, int remove);
      clean_th = clean;
      remove_th = remove;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function void add_event(logic [3:0] kind, logic [15:0] due, logic [7:0] pay);
      if (err_mode) return;
      count++;
      if (count >= DEPTH) begin
        ev_kind[0] = K_ERROR;
        ev_pay[0] = ERR_FULL;
        count = 1;
      end else begin
        ev_kind[count-1] = kind;
        ev_due[count-1] = due;
        ev_pay[count-1] = pay;
        ev_dead[count-1] = 0;
      end
    endfunction

    function int pick_event(logic [15:0] now);
      int cand;
      int pushb;
      logic [15:0] prev;
      cand = DEPTH;
      pushb = DEPTH;
      prev = now - 16'd1;
      for (int i = 0; i < count && i < DEPTH; i++) begin
        if (ev_dead[i]) continue;
        if (ev_kind[i] == K_ERROR) return i;
        if (ev_due[i] == now || ev_due[i] == prev) cand = i;
        if (ev_kind[i] == K_PUSHB) pushb = i;
      end
      if (cand < DEPTH && ev_kind[cand] == K_PUSHA && pushb < DEPTH) return pushb;
      return cand;
    endfunction

    function void compact_table();
      int wr;
      wr = 0;
      for (int rd = 0; rd < count && rd < DEPTH; rd++) begin
        if (ev_dead[rd]) continue;
        ev_kind[wr] = ev_kind[rd];
        ev_due[wr] = ev_due[rd];
        ev_pay[wr] = ev_pay[rd];
        ev_dead[wr] = ev_dead[rd];
        wr++;
      end
      count = wr;
    endfunction

    function word_t mk(logic [2:0] a, logic [1:0] l, logic v, logic [7:0] p,
                       logic [7:0] w, logic [7:0] e);
      word_t r;
      r.action = a; r.led = l; r.level = v; r.pkg = p; r.weight = w; r.err = e;
      r.count = count[4:0];
      r.last = 0;
      return r;
    endfunction

    function void note_item(logic [1:0] op, logic [3:0] kind, logic [15:0] due,
                            logic [7:0] pay, logic [15:0] now);
      word_t burst[$];
      logic [7:0] pkg;
      logic [3:0] k;
      logic [7:0] p;
      int idx;
      if (op == OP_ADD) begin
        add_event(kind, due, pay);
      end else if (op == OP_COMP) begin
        compact_table();
      end else if (op == OP_START) begin
        count = 0;
        err_mode = 0;
      end else begin
        pkg = 0;
        while (burst.size() < BURST) begin
          idx = pick_event(now);
          if (idx >= DEPTH) break;
          k = ev_kind[idx];
          p = ev_pay[idx];
          if (k == K_PUSHA) begin
            if (scale_idle) begin
              scale_idle = 0;
              pkg = p;
              add_event(K_PES_ON, now, 8'd0);
              add_event(K_PES_OFF, now + 16'd1, 8'd0);
              burst.push_back(mk(A_PULSA, 0, 0, 0, 0, 0));
            end else begin
              burst.push_back(mk(A_NONE, 0, 0, 0, 0, 0));
            end
          end else if (k == K_PUSHB) begin
            scale_idle = 1;
            pkg = 0;
            burst.push_back(mk(A_PULSB, 0, 0, 0, 0, 0));
          end else if (k >= K_LEDON_LO && k <= K_LEDON_HI) begin
            burst.push_back(mk(A_LED, 2'(k - K_LEDON_LO), 0, 0, 0, 0));
          end else if (k >= K_LEDOFF_LO && k <= K_LEDOFF_HI) begin
            burst.push_back(mk(A_LED, 2'(k - K_LEDOFF_LO), 1, 0, 0, 0));
          end else if (k == K_PES_ON) begin
            burst.push_back(mk(A_PES, 0, 1, 0, 0, 0));
          end else if (k == K_PES_OFF) begin
            burst.push_back(mk(A_PES, 0, 0, 0, 0, 0));
          end else if (k == K_PRINT) begin
            burst.push_back(mk(A_PRINT, 0, 0, pkg, p, 0));
          end else if (k == K_ERROR) begin
            count = 0;
            err_mode = 1;
            scale_idle = 1;
            burst.push_back(mk(A_ERROR, 0, 0, 0, 0, p));
          end else begin
            add_event(K_ERROR, now, ERR_UNKNOWN);
            burst.push_back(mk(A_NONE, 0, 0, 0, 0, ERR_UNKNOWN));
          end
          ev_dead[idx] = !ev_dead[idx];
        end
        if (count > remove_th) begin
        end else if (count > clean_th) begin
          compact_table();
        end
        if (burst.size() > 0) burst[burst.size()-1].count = count[4:0];
      end
      if (burst.size() == 0) burst.push_back(mk(A_NONE, 0, 0, 0, 0, 0));
      burst[burst.size()-1].last = 1;
      foreach (burst[i]) pending_words.push_back(burst[i]);
    endfunction

    function void check_word(word_t got);
      word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word action=%0d", got.action);
        return;
      end
      want = pending_words.pop_front();
      checked++;
      served[want.action]++;
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch word %0d: exp act=%0d led=%0d lvl=%0d pkg=%0d wt=%0d err=%0d",
            checked, want.action, want.led, want.level, want.pkg, want.weight, want.err,
            " cnt=%0d last=%0d", want.count, want.last);
          $display("  got act=%0d led=%0d lvl=%0d pkg=%0d wt=%0d err=%0d cnt=%0d last=%0d",
            got.action, got.led, got.level, got.pkg, got.weight, got.err,
            got.count, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_op = 0;
  logic [3:0]  in_event_kind = 0;
  logic [15:0] in_due_time = 0;
  logic [7:0]  in_payload = 0;
  logic [15:0] in_now_time = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_action;
  logic [1:0]  out_led_index;
  logic        out_line_level;
  logic [7:0]  out_package_kind;
  logic [7:0]  out_weight;
  logic [7:0]  out_error_code;
  logic [4:0]  out_queue_count;
  logic        out_last;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [4:0]  cfg_wdata = 0;

  deadline_event_queue_dispatcher_top dut (.*);

  dispatch_scoreboard sb = new();
  bit          calm = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  logic [15:0] now = 16'd100;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(negedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);

  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid && out_ready) begin
      w.action = out_action; w.led = out_led_index; w.level = out_line_level;
      w.pkg = out_package_kind; w.weight = out_weight; w.err = out_error_code;
      w.count = out_queue_count; w.last = out_last;
      sb.check_word(w);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("watchdog: no handshake for %0d cycles", STALL_MAX);
      $display("deadline_event_queue_dispatcher_top verification failed");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] kind, logic [15:0] due,
                           logic [7:0] pay, logic [15:0] t);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_event_kind <= kind;
    in_due_time <= due;
    in_payload <= pay;
    in_now_time <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_item(op, kind, due, pay, t);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_thresholds(logic [4:0] clean, logic [4:0] remove);
    cfg_we <= 1;
    cfg_index <= CFG_CLEAN;
    cfg_wdata <= clean;
    @(negedge clk);
    cfg_index <= CFG_REMOVE;
    cfg_wdata <= remove;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_thresholds(clean, remove);
  endtask

  function automatic logic [3:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 20) return K_PUSHA;
    if (r < 35) return K_PUSHB;
    if (r < 50) return K_PRINT;
    if (r < 54) return K_ERROR;
    if (r < 58) return 4'($urandom_range(14, 15));
    return 4'($urandom_range(2, 11));
  endfunction

  task automatic random_phase(int n_items);
    int stop_at;
    int n_adds;
    logic [15:0] due;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(9) == 0)
          send_item(OP_START, 4'($urandom), 16'($urandom), 8'($urandom), now);
        n_adds = $urandom_range(1, 6);
        repeat (n_adds) begin
          case ($urandom_range(3))
            0: due = now;
            1: due = now - 16'd1;
            2: due = now + 16'($urandom_range(1, 3));
            default: due = 16'($urandom);
          endcase
          send_item(OP_ADD, pick_kind(), due, 8'($urandom), now);
        end
        now = now + 16'($urandom_range(0, 1));
        send_item(OP_DISP, 4'($urandom), 16'($urandom), 8'($urandom), now);
        if ($urandom_range(3) == 0)
          send_item(OP_DISP, 4'($urandom), 16'($urandom), 8'($urandom), now + 16'd1);
        if ($urandom_range(5) == 0)
          send_item(OP_COMP, 4'($urandom), 16'($urandom), 8'($urandom), now);
      end else begin
        send_item(2'($urandom), 4'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      end
      if ($urandom_range(19) == 0) now = 16'($urandom);
      else now = now + 16'($urandom_range(0, 2));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    set_thresholds(5'd8, 5'd12);

    // every kind once, sixteenth add overflows into the queue-full entry
    for (int k = 0; k < 16; k++)
      send_item(OP_ADD, 4'(k), (k % 2) ? 16'hFFFF : 16'h0000,
                (k % 2) ? 8'hFF : 8'h00, 16'h0000);
    send_item(OP_DISP, 4'h0, 16'h0, 8'h0, 16'h0000);
    send_item(OP_ADD, K_PRINT, 16'h0, 8'h55, 16'h0000);
    send_item(OP_START, 4'hF, 16'hFFFF, 8'hFF, 16'hFFFF);
    // deadline one tick behind across the wrap
    send_item(OP_ADD, K_PUSHA, 16'hFFFF, 8'hA5, 16'h0000);
    send_item(OP_ADD, K_PRINT, 16'h0000, 8'hFF, 16'h0000);
    send_item(OP_ADD, 4'd14, 16'h1234, 8'h00, 16'h0000);
    send_item(OP_DISP, 4'h0, 16'h0, 8'h0, 16'h0000);
    send_item(OP_ADD, K_PUSHB, 16'h0001, 8'h00, 16'h0001);
    send_item(OP_ADD, K_PUSHA, 16'h0001, 8'h01, 16'h0001);
    send_item(OP_DISP, 4'h0, 16'h0, 8'h0, 16'h0001);
    send_item(OP_COMP, 4'h0, 16'h0, 8'h0, 16'h0001);
    send_item(OP_DISP, 4'h0, 16'h0, 8'h0, 16'h8000);
    send_item(OP_START, 4'h0, 16'h0, 8'h0, 16'h0);
    drain();

    random_phase(40);
    drain();
    set_thresholds(5'd0, 5'd0);
    random_phase(40);
    drain();
    set_thresholds(5'd16, 5'd16);
    calm = 1;
    random_phase(40);
    calm = 0;
    drain();
    set_thresholds(5'd0, 5'd16);
    random_phase(40);
    drain();
    set_thresholds(5'd16, 5'd0);
    random_phase(35);
    drain();
    set_thresholds(5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)));
    random_phase(35);
    drain();

    $display("%0d input words, %0d result words checked (%0d pulse A, %0d pulse B,",
      items_sent, sb.checked, sb.served[A_PULSA], sb.served[A_PULSB],
      " %0d led, %0d pes, %0d print, %0d error); six threshold settings, %0d mismatches",
      sb.served[A_LED], sb.served[A_PES], sb.served[A_PRINT], sb.served[A_ERROR],
      sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("deadline_event_queue_dispatcher_top verification clean");
    else
      $display("deadline_event_queue_dispatcher_top verification failed");
    $finish;
  end
endmodule
